@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL; the replacement core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define PCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define PCR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCR_ASSERT(label, clk, rst_n, prop, msg)
`define PCR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ hw/rtl/pcrrip_pkg.sv @@
// Types and constants of the PC-signature RRIP replacement block.
package pcrrip_pkg;

    // Payload field widths
    localparam int OP_W    = 1;
    localparam int CORE_W  = 2;
    localparam int SET_W   = 11;
    localparam int WAYF_W  = 4;
    localparam int PC_W    = 12;
    localparam int SIG_W   = 12;

    // Operation codes
    localparam logic [OP_W-1:0] OP_VICTIM = 1'b0;
    localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  LOW_THRESHOLD_RESET  = 5'd10;
    localparam logic [CFG_DATA_W-1:0]  HIGH_THRESHOLD_RESET = 5'd20;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_AGE,
        ST_HIT,
        ST_CTR_RD_OLD,
        ST_CTR_WR_OLD,
        ST_CTR_RD_NEW,
        ST_INSERT,
        ST_EMIT
    } t_state;

endpackage

@@ hw/rtl/pcrrip_item_if.sv @@
// Input channel: victim requests and access updates.
interface pcrrip_item_if;
    logic                           valid;
    logic                           ready;
    logic [pcrrip_pkg::OP_W-1:0]    operation;
    logic [pcrrip_pkg::CORE_W-1:0]  core;
    logic [pcrrip_pkg::SET_W-1:0]   set_index;
    logic [pcrrip_pkg::WAYF_W-1:0]  way_index;
    logic [pcrrip_pkg::PC_W-1:0]    pc_low_bits;
    logic                           was_hit;

    modport source (
        output valid, operation, core, set_index, way_index, pc_low_bits, was_hit,
        input  ready
    );
    modport sink (
        input  valid, operation, core, set_index, way_index, pc_low_bits, was_hit,
        output ready
    );
endinterface

@@ hw/rtl/pcrrip_result_if.sv @@
// Result channel: chosen victim way.
interface pcrrip_result_if;
    logic                           valid;
    logic                           ready;
    logic [pcrrip_pkg::WAYF_W-1:0]  victim_way;

    modport source (output valid, victim_way, input ready);
    modport sink   (input valid, victim_way, output ready);
endinterface

@@ hw/rtl/pcrrip_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pcrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ hw/rtl/pc_signature_rrip_replacement_core.sv @@
// PC-signature RRIP replacement core: sequencer, set-row and counter memories.
//
//  channel   | dir | payload                                             | beat when
//  i_item    | in  | operation core set_index way_index pc_low_bits was_hit | valid & ready
//  o_result  | out | victim_way                                          | valid & ready
//  i_cfg_*   | in  | i_cfg_index i_cfg_data                              | i_cfg_we
//
// Victim request: one way compared per cycle by a shared compare unit, then one aging
// write-back; a scan that reaches an invalid way picks it and skips the aging. Miss
// updates read and write the counter memory in turn (it has one read and one write port).
// Reset starts a clearing pass over both memories; i_item.ready stays low during it.
// A finished result sits in the output register; a new beat is taken meanwhile.
`include "assert_macros.svh"

module pc_signature_rrip_replacement_core #(
    parameter int NUM_CORES     = 1,
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int RRPV_WIDTH    = 2,
    parameter int COUNTER_WIDTH = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcrrip_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [pcrrip_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pcrrip_item_if.sink                         i_item,
    pcrrip_result_if.source                     o_result
);
    localparam int ROWS        = NUM_CORES * NUM_SETS;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int SIG_W       = pcrrip_pkg::SIG_W;
    localparam int SIG_ENTRIES = 1 << SIG_W;
    localparam int CLR_N       = (ROWS > SIG_ENTRIES) ? ROWS : SIG_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_N);
    localparam int CMP_W       = (COUNTER_WIDTH > pcrrip_pkg::CFG_DATA_W) ?
                                 COUNTER_WIDTH : pcrrip_pkg::CFG_DATA_W;

    localparam logic [RRPV_WIDTH-1:0]    RRPV_MAX = '1;
    localparam logic [COUNTER_WIDTH-1:0] CTR_MAX  = '1;
    localparam logic [COUNTER_WIDTH-1:0] CTR_INIT = CTR_MAX >> 1;

    typedef struct packed {
        logic [RRPV_WIDTH-1:0] rrpv;
        logic                  valid;
        logic                  reused;
        logic [SIG_W-1:0]      sig;
    } t_lane;

    typedef t_lane [NUM_WAYS-1:0] t_row;

    localparam int ROW_BITS = $bits(t_row);

    pcrrip_pkg::t_state r_state, n_state;

    logic [CLR_W-1:0]                   r_clr;
    logic [pcrrip_pkg::OP_W-1:0]        r_op;
    logic                               r_hit;
    logic [ROW_W-1:0]                   r_row;
    logic [WAY_W-1:0]                   r_way;
    logic [SIG_W-1:0]                   r_sig;
    logic [WAY_W-1:0]                   r_scan;
    logic [RRPV_WIDTH-1:0]              r_top;
    logic [WAY_W-1:0]                   r_first;
    logic [WAY_W-1:0]                   r_victim;
    logic                               r_out_valid;
    logic [pcrrip_pkg::WAYF_W-1:0]      r_out_victim;
    logic [pcrrip_pkg::CFG_DATA_W-1:0]  r_low_thr;
    logic [pcrrip_pkg::CFG_DATA_W-1:0]  r_high_thr;

    logic                     row_we;
    logic [ROW_W-1:0]         row_waddr;
    t_row                     row_wdata;
    logic [ROW_BITS-1:0]      row_rdata;
    t_row                     row_q;

    logic                     ctr_we;
    logic [SIG_W-1:0]         ctr_waddr;
    logic [COUNTER_WIDTH-1:0] ctr_wdata;
    logic [SIG_W-1:0]         ctr_raddr;
    logic [COUNTER_WIDTH-1:0] ctr_rdata;

    logic                     accept;
    logic                     in_range;
    logic                     way_ok;
    logic                     out_free;
    logic                     clr_last;
    t_lane                    scan_lane;
    t_lane                    upd_lane;
    logic [RRPV_WIDTH-1:0]    age;
    logic [RRPV_WIDTH-1:0]    ins_rrpv;
    logic [COUNTER_WIDTH-1:0] trained;

    assign row_q     = t_row'(row_rdata);
    assign scan_lane = row_q[r_scan];
    assign upd_lane  = row_q[r_way];
    assign age       = RRPV_MAX - r_top;
    assign clr_last  = (r_clr == CLR_W'(CLR_N - 1));
    assign out_free  = !r_out_valid || o_result.ready;

    assign i_item.ready = (r_state == pcrrip_pkg::ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign in_range     = (int'(i_item.core) < NUM_CORES) &&
                          (int'(i_item.set_index) < NUM_SETS);
    assign way_ok       = (int'(i_item.way_index) < NUM_WAYS);

    assign o_result.valid      = r_out_valid;
    assign o_result.victim_way = r_out_victim;

    // Saturating train of the evicted line's counter
    always_comb begin
        if (upd_lane.reused) begin
            trained = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + 1'b1;
        end else begin
            trained = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - 1'b1;
        end
    end

    always_comb begin
        if (CMP_W'(ctr_rdata) > CMP_W'(r_high_thr)) begin
            ins_rrpv = '0;
        end else if (CMP_W'(ctr_rdata) > CMP_W'(r_low_thr)) begin
            ins_rrpv = RRPV_WIDTH'(1);
        end else begin
            ins_rrpv = RRPV_MAX;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcrrip_pkg::ST_CLEAR: begin
                if (clr_last) n_state = pcrrip_pkg::ST_IDLE;
            end
            pcrrip_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_item.operation == pcrrip_pkg::OP_VICTIM) begin
                        n_state = in_range ? pcrrip_pkg::ST_READ : pcrrip_pkg::ST_EMIT;
                    end else if (in_range && way_ok) begin
                        n_state = pcrrip_pkg::ST_READ;
                    end
                end
            end
            pcrrip_pkg::ST_READ: begin
                if (r_op == pcrrip_pkg::OP_VICTIM) begin
                    n_state = pcrrip_pkg::ST_SCAN;
                end else if (r_hit) begin
                    n_state = pcrrip_pkg::ST_HIT;
                end else begin
                    n_state = pcrrip_pkg::ST_CTR_RD_OLD;
                end
            end
            pcrrip_pkg::ST_SCAN: begin
                if (!scan_lane.valid) begin
                    n_state = pcrrip_pkg::ST_EMIT;
                end else if (r_scan == WAY_W'(NUM_WAYS - 1)) begin
                    n_state = pcrrip_pkg::ST_AGE;
                end
            end
            pcrrip_pkg::ST_AGE:        n_state = pcrrip_pkg::ST_EMIT;
            pcrrip_pkg::ST_HIT:        n_state = pcrrip_pkg::ST_IDLE;
            pcrrip_pkg::ST_CTR_RD_OLD: begin
                n_state = upd_lane.valid ? pcrrip_pkg::ST_CTR_WR_OLD
                                         : pcrrip_pkg::ST_CTR_RD_NEW;
            end
            pcrrip_pkg::ST_CTR_WR_OLD: n_state = pcrrip_pkg::ST_CTR_RD_NEW;
            pcrrip_pkg::ST_CTR_RD_NEW: n_state = pcrrip_pkg::ST_INSERT;
            pcrrip_pkg::ST_INSERT:     n_state = pcrrip_pkg::ST_IDLE;
            pcrrip_pkg::ST_EMIT: begin
                if (out_free) n_state = pcrrip_pkg::ST_IDLE;
            end
            default:                   n_state = pcrrip_pkg::ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_row;
        row_wdata = row_q;
        ctr_we    = 1'b0;
        ctr_waddr = upd_lane.sig;
        ctr_wdata = trained;
        ctr_raddr = r_sig;
        unique case (r_state)
            pcrrip_pkg::ST_CLEAR: begin
                row_we    = (int'(r_clr) < ROWS);
                row_waddr = ROW_W'(r_clr);
                for (int w = 0; w < NUM_WAYS; w++) begin
                    row_wdata[w] = '{rrpv: RRPV_MAX, valid: 1'b0, reused: 1'b0, sig: '0};
                end
                ctr_we    = (int'(r_clr) < SIG_ENTRIES);
                ctr_waddr = SIG_W'(r_clr);
                ctr_wdata = CTR_INIT;
            end
            pcrrip_pkg::ST_AGE: begin
                row_we = 1'b1;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    row_wdata[w].rrpv = row_q[w].rrpv + age;
                end
            end
            pcrrip_pkg::ST_HIT: begin
                row_we = 1'b1;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (WAY_W'(w) == r_way) begin
                        row_wdata[w].rrpv   = '0;
                        row_wdata[w].reused = 1'b1;
                    end
                end
            end
            pcrrip_pkg::ST_CTR_RD_OLD: begin
                ctr_raddr = upd_lane.sig;
            end
            pcrrip_pkg::ST_CTR_WR_OLD: begin
                ctr_we = 1'b1;
            end
            pcrrip_pkg::ST_INSERT: begin
                row_we = 1'b1;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (WAY_W'(w) == r_way) begin
                        row_wdata[w] = '{rrpv: ins_rrpv, valid: 1'b1, reused: 1'b0,
                                         sig: r_sig};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcrrip_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_low_thr   <= pcrrip_pkg::LOW_THRESHOLD_RESET;
            r_high_thr  <= pcrrip_pkg::HIGH_THRESHOLD_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == pcrrip_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == pcrrip_pkg::ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pcrrip_pkg::REG_LOW_THRESHOLD:  r_low_thr  <= i_cfg_data;
                    pcrrip_pkg::REG_HIGH_THRESHOLD: r_high_thr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_item.operation;
            r_hit    <= i_item.was_hit;
            r_row    <= ROW_W'(int'(i_item.core) * NUM_SETS + int'(i_item.set_index));
            r_way    <= WAY_W'(i_item.way_index);
            r_sig    <= SIG_W'(i_item.pc_low_bits);
            r_scan   <= '0;
            r_top    <= '0;
            r_first  <= '0;
            r_victim <= '0;
        end
        if (r_state == pcrrip_pkg::ST_SCAN) begin
            if (!scan_lane.valid) begin
                r_victim <= r_scan;
            end else begin
                // keep the first way holding the largest value
                if (scan_lane.rrpv > r_top) begin
                    r_top   <= scan_lane.rrpv;
                    r_first <= r_scan;
                end
                r_scan <= r_scan + 1'b1;
            end
        end
        if (r_state == pcrrip_pkg::ST_AGE) begin
            r_victim <= r_first;
        end
        if (r_state == pcrrip_pkg::ST_EMIT && out_free) begin
            r_out_victim <= pcrrip_pkg::WAYF_W'(r_victim);
        end
    end

    pcrrip_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_row),
        .o_rdata (row_rdata)
    );

    pcrrip_ram #(
        .WIDTH (COUNTER_WIDTH),
        .DEPTH (SIG_ENTRIES)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (ctr_waddr),
        .i_wdata (ctr_wdata),
        .i_raddr (ctr_raddr),
        .o_rdata (ctr_rdata)
    );

    `PCR_ASSERT(a_scan_no_write, i_clk, i_rst_n, (r_state == pcrrip_pkg::ST_SCAN) |-> (!row_we && !ctr_we), "memory written during way scan")
    `PCR_ASSERT(a_both_writes_clear, i_clk, i_rst_n, (row_we && ctr_we) |-> (r_state == pcrrip_pkg::ST_CLEAR), "row and counter written together outside clearing pass")
    `PCR_ASSERT(a_result_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == pcrrip_pkg::ST_EMIT), "result loaded outside emit state")
    `PCR_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == pcrrip_pkg::ST_SCAN) |-> (r_scan <= WAY_W'(NUM_WAYS - 1)), "scan index past last way")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the PC-signature RRIP replacement core.
module tb;

    localparam int L_CORES        = 1;
    localparam int L_SETS         = 2048;
    localparam int L_WAYS         = 16;
    localparam int RRPV_TOP       = 3;
    localparam int CTR_TOP        = 31;
    localparam int CTR_START      = 15;
    localparam int SIG_COUNT      = 4096;
    localparam int LINE_COUNT     = L_CORES * L_SETS * L_WAYS;
    localparam int SETTLE         = 30;
    localparam int RAND_PER_PHASE = 300;
    localparam int N_PHASES       = 5;
    localparam int HOLD_CYCLES    = 400;
    localparam int SET_POOL       = 12;
    localparam int SIG_POOL       = 16;

    typedef struct packed {
        logic [pcrrip_pkg::OP_W-1:0]   operation;
        logic [pcrrip_pkg::CORE_W-1:0] core;
        logic [pcrrip_pkg::SET_W-1:0]  set_index;
        logic [pcrrip_pkg::WAYF_W-1:0] way_index;
        logic [pcrrip_pkg::PC_W-1:0]   pc_low_bits;
        logic                          was_hit;
        logic                          take_victim;  // fill or hit the way last chosen
    } t_beat;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [pcrrip_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [pcrrip_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    pcrrip_item_if   item_ch ();
    pcrrip_result_if result_ch ();

    pc_signature_rrip_replacement_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // Replacement state as the block should hold it
    logic [1:0]                   rrpv_mem   [LINE_COUNT];
    logic                         line_vld   [LINE_COUNT];
    logic                         line_reuse [LINE_COUNT];
    logic [pcrrip_pkg::SIG_W-1:0] line_sig   [LINE_COUNT];
    logic [4:0]                   sig_ctr    [SIG_COUNT];
    logic [4:0]                   low_thr;
    logic [4:0]                   high_thr;
    logic [3:0]                   last_victim;

    logic [pcrrip_pkg::SET_W-1:0] set_pool [SET_POOL] = '{11'd0, 11'd2047, 11'd1, 11'd1024,
                                                          11'd341, 11'd1706, 11'd682, 11'd1365,
                                                          11'd5, 11'd2000, 11'd100, 11'd777};
    logic [pcrrip_pkg::PC_W-1:0]  sig_pool [SIG_POOL];

    t_beat                         pending_beats [$];
    logic [pcrrip_pkg::WAYF_W-1:0] expected_victims [$];
    t_beat                         cur_beat;
    bit                            driver_busy;
    logic [pcrrip_pkg::WAYF_W-1:0] want_way;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_trigger;
    int hold_seen;
    int hold_left;
    int err_count;
    int n_victims;
    int n_updates;
    int n_ignored;
    int n_checked;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // First invalid way, else age the set until a way reaches the top value
    function automatic logic [3:0] find_victim(int unsigned base);
        logic [1:0] top;
        top = '0;
        for (int w = 0; w < L_WAYS; w++)
            if (!line_vld[base + w]) return 4'(w);
        for (int w = 0; w < L_WAYS; w++)
            if (rrpv_mem[base + w] > top) top = rrpv_mem[base + w];
        if (top != 2'(RRPV_TOP))
            for (int w = 0; w < L_WAYS; w++)
                rrpv_mem[base + w] = rrpv_mem[base + w] + (2'(RRPV_TOP) - top);
        for (int w = 0; w < L_WAYS; w++)
            if (rrpv_mem[base + w] == 2'(RRPV_TOP)) return 4'(w);
        return 4'd0;
    endfunction

    function automatic void predict_access(t_beat b);
        int unsigned                  base;
        int unsigned                  line;
        logic [pcrrip_pkg::SIG_W-1:0] old_sig;
        logic [4:0]                   ctr;
        logic [3:0]                   v;
        bit                           in_range;
        in_range = (b.core < L_CORES) && (b.set_index < L_SETS);
        base = (b.core * L_SETS + b.set_index) * L_WAYS;
        if (b.operation == pcrrip_pkg::OP_VICTIM) begin
            v = in_range ? find_victim(base) : 4'd0;
            expected_victims.push_back(v);
            last_victim = v;
            n_victims++;
            return;
        end
        n_updates++;
        if (!in_range || b.way_index >= L_WAYS) begin
            n_ignored++;
            return;
        end
        line = base + b.way_index;
        if (b.was_hit) begin
            line_reuse[line] = 1'b1;
            rrpv_mem[line] = 2'd0;
            return;
        end
        // Train the evicted line's signature before installing the new one
        if (line_vld[line]) begin
            old_sig = line_sig[line];
            if (line_reuse[line]) begin
                if (sig_ctr[old_sig] < CTR_TOP) sig_ctr[old_sig]++;
            end else begin
                if (sig_ctr[old_sig] > 0) sig_ctr[old_sig]--;
            end
        end
        line_vld[line] = 1'b1;
        line_reuse[line] = 1'b0;
        line_sig[line] = b.pc_low_bits;
        ctr = sig_ctr[b.pc_low_bits];
        if (ctr > high_thr)
            rrpv_mem[line] = 2'd0;
        else if (ctr > low_thr)
            rrpv_mem[line] = 2'd1;
        else
            rrpv_mem[line] = 2'(RRPV_TOP);
    endfunction

    // Driver: present queued beats, update the prediction on each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_access(cur_beat);
                driver_busy = 1'b0;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    if (cur_beat.take_victim) cur_beat.way_index = last_victim;
                    driver_busy = 1'b1;
                    item_ch.operation   <= cur_beat.operation;
                    item_ch.core        <= cur_beat.core;
                    item_ch.set_index   <= cur_beat.set_index;
                    item_ch.way_index   <= cur_beat.way_index;
                    item_ch.pc_low_bits <= cur_beat.pc_low_bits;
                    item_ch.was_hit     <= cur_beat.was_hit;
                    item_ch.valid       <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat and drive backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_victims.size() == 0) begin
                    $error("victim_way beat with no request waiting: actual %0d",
                           result_ch.victim_way);
                    err_count++;
                end else begin
                    want_way = expected_victims.pop_front();
                    n_checked++;
                    if (result_ch.victim_way !== want_way) begin
                        $error("victim_way mismatch: expected %0d, actual %0d",
                               want_way, result_ch.victim_way);
                        err_count++;
                    end
                end
            end
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_beat(logic [pcrrip_pkg::OP_W-1:0] op,
                             logic [pcrrip_pkg::CORE_W-1:0] core,
                             logic [pcrrip_pkg::SET_W-1:0] set_index,
                             logic [pcrrip_pkg::WAYF_W-1:0] way,
                             logic [pcrrip_pkg::PC_W-1:0] pc, logic hit, logic take_victim);
        t_beat b;
        b = '{op, core, set_index, way, pc, hit, take_victim};
        pending_beats.push_back(b);
    endtask

    task automatic write_reg(logic [pcrrip_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pcrrip_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pcrrip_pkg::REG_LOW_THRESHOLD)
            low_thr = val;
        else
            high_thr = val;
    endtask

    // Wait until every beat is taken and every result checked, then let updates finish
    task automatic settle_block();
        while (pending_beats.size() != 0 || driver_busy || expected_victims.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        int                            counted;
        int                            pick;
        int                            g;
        logic [pcrrip_pkg::OP_W-1:0]   op;
        logic [pcrrip_pkg::CORE_W-1:0] core;
        logic [pcrrip_pkg::SET_W-1:0]  set_sel;
        logic [pcrrip_pkg::PC_W-1:0]   pc_sel;
        bit                            friendly;
        counted = 0;
        while (counted < n) begin
            pick = $urandom_range(99);
            set_sel = set_pool[$urandom_range(SET_POOL - 1)];
            g = $urandom_range(SIG_POOL - 1);
            pc_sel = sig_pool[g];
            friendly = (g < SIG_POOL / 2);
            if (pick < 15) begin
                // noise: any field value, out-of-range cores included
                op = $urandom_range(1) ? pcrrip_pkg::OP_UPDATE : pcrrip_pkg::OP_VICTIM;
                core = $urandom_range(1) ? pcrrip_pkg::CORE_W'($urandom_range(3)) : '0;
                if ($urandom_range(1))
                    set_sel = pcrrip_pkg::SET_W'($urandom_range(L_SETS - 1));
                push_beat(op, core, set_sel, pcrrip_pkg::WAYF_W'($urandom_range(15)),
                          pcrrip_pkg::PC_W'($urandom_range(4095)), 1'($urandom_range(1)),
                          1'b0);
                if (!(op == pcrrip_pkg::OP_UPDATE && core >= L_CORES)) counted++;
            end else if (pick < 60) begin
                // miss: ask for a victim, fill it, maybe reuse it
                push_beat(pcrrip_pkg::OP_VICTIM, '0, set_sel,
                          pcrrip_pkg::WAYF_W'($urandom_range(15)),
                          pcrrip_pkg::PC_W'($urandom_range(4095)), 1'($urandom_range(1)),
                          1'b0);
                push_beat(pcrrip_pkg::OP_UPDATE, '0, set_sel, '0, pc_sel, 1'b0, 1'b1);
                counted += 2;
                if ($urandom_range(99) < (friendly ? 75 : 10)) begin
                    push_beat(pcrrip_pkg::OP_UPDATE, '0, set_sel, '0,
                              sig_pool[$urandom_range(SIG_POOL - 1)], 1'b1, 1'b1);
                    counted++;
                end
            end else if (pick < 90) begin
                push_beat(pcrrip_pkg::OP_UPDATE, '0, set_sel,
                          pcrrip_pkg::WAYF_W'($urandom_range(15)), pc_sel, 1'b1, 1'b0);
                counted++;
            end else begin
                push_beat(pcrrip_pkg::OP_VICTIM, '0, set_sel,
                          pcrrip_pkg::WAYF_W'($urandom_range(15)), pc_sel,
                          1'($urandom_range(1)), 1'b0);
                counted++;
            end
        end
    endtask

    initial begin : stimulus
        logic [4:0] low_set  [N_PHASES];
        logic [4:0] high_set [N_PHASES];
        int         n_top;
        int         n_zero;
        low_set  = '{5'd0, 5'd31, 5'd5, 5'd31, 5'd0};
        high_set = '{5'd31, 5'd0, 5'd12, 5'd31, 5'd0};

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        item_ch.valid         = 1'b0;
        item_ch.operation     = '0;
        item_ch.core          = '0;
        item_ch.set_index     = '0;
        item_ch.way_index     = '0;
        item_ch.pc_low_bits   = '0;
        item_ch.was_hit       = 1'b0;
        result_ch.ready       = 1'b0;
        driver_busy           = 1'b0;
        hold_trigger          = 0;
        hold_seen             = 0;
        hold_left             = 0;
        err_count             = 0;
        n_settings            = 1;

        for (int i = 0; i < LINE_COUNT; i++) begin
            rrpv_mem[i]   = 2'(RRPV_TOP);
            line_vld[i]   = 1'b0;
            line_reuse[i] = 1'b0;
            line_sig[i]   = '0;
        end
        for (int i = 0; i < SIG_COUNT; i++) sig_ctr[i] = 5'(CTR_START);
        low_thr  = pcrrip_pkg::LOW_THRESHOLD_RESET;
        high_thr = pcrrip_pkg::HIGH_THRESHOLD_RESET;
        last_victim = '0;

        sig_pool[0] = '0;
        sig_pool[SIG_POOL - 1] = '1;
        for (int i = 1; i < SIG_POOL - 1; i++)
            sig_pool[i] = pcrrip_pkg::PC_W'($urandom_range(4095));

        tx_idle_pct = 22;
        rx_idle_pct = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, thresholds at their reset values
        push_beat(pcrrip_pkg::OP_VICTIM, 2'd0, 11'd0, 4'd0, 12'd0, 1'b0, 1'b0);     // empty set
        push_beat(pcrrip_pkg::OP_UPDATE, 2'd0, 11'd0, 4'd0, 12'd0, 1'b0, 1'b0);
        // hit on invalid line
        push_beat(pcrrip_pkg::OP_UPDATE, 2'd0, 11'd0, 4'd15, 12'hFFF, 1'b1, 1'b0);
        push_beat(pcrrip_pkg::OP_VICTIM, 2'd0, 11'd0, 4'd15, 12'hFFF, 1'b1, 1'b0);
        // no training
        push_beat(pcrrip_pkg::OP_UPDATE, 2'd0, 11'd0, 4'd15, 12'hABC, 1'b0, 1'b0);
        // core out of range
        push_beat(pcrrip_pkg::OP_VICTIM, 2'd3, 11'd2047, 4'd15, 12'hFFF, 1'b1, 1'b0);
        // ignored
        push_beat(pcrrip_pkg::OP_UPDATE, 2'd1, 11'd2047, 4'd3, 12'd7, 1'b0, 1'b0);
        for (int w = 0; w < L_WAYS; w++)
            push_beat(pcrrip_pkg::OP_UPDATE, 2'd0, 11'd2047, 4'(w),
                      (w == L_WAYS - 1) ? 12'hFFF : 12'(w * 273), 1'b0, 1'b0);
        // full set ages
        push_beat(pcrrip_pkg::OP_VICTIM, 2'd0, 11'd2047, 4'd0, 12'd0, 1'b0, 1'b0);
        push_beat(pcrrip_pkg::OP_UPDATE, 2'd0, 11'd2047, 4'd0, 12'd0, 1'b1, 1'b0);
        push_beat(pcrrip_pkg::OP_VICTIM, 2'd0, 11'd2047, 4'd0, 12'd0, 1'b0, 1'b0);
        settle_block();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(pcrrip_pkg::REG_LOW_THRESHOLD, low_set[p]);
            write_reg(pcrrip_pkg::REG_HIGH_THRESHOLD, high_set[p]);
            n_settings++;
            if (p < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 48;
            end else if (p < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_trigger++;  // long result stall while beats keep coming
            end
            queue_random(RAND_PER_PHASE);
            settle_block();
        end

        if (expected_victims.size() != 0) begin
            $error("victim_way: %0d expected results never arrived", expected_victims.size());
            err_count++;
        end

        n_top = 0;
        n_zero = 0;
        for (int i = 0; i < SIG_COUNT; i++) begin
            if (sig_ctr[i] == CTR_TOP) n_top++;
            if (sig_ctr[i] == 0) n_zero++;
        end
        $display("Run covered %0d victim requests (%0d results checked), %0d updates (%0d ignored)",
                 n_victims, n_checked, n_updates, n_ignored);
        $display("Threshold settings used: %0d; counters saturated high %0d, low %0d",
                 n_settings, n_top, n_zero);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
